// ----- rtl/ptsp_pkg.sv -----
// Shared constants and types for the palette texel resampler.
`default_nettype none

package ptsp_pkg;

	localparam int PAL_DEPTH  = 256;
	localparam int PAL_IDX_W  = 8;
	localparam int COLOR_W    = 32;
	localparam int TEXEL_W    = 8;
	localparam int TADDR_W    = 17;
	localparam int ROW_W      = 8;
	localparam int COL_W      = 9;
	localparam int IW_W       = 10;
	localparam int IH_W       = 9;
	localparam int FRAC_W     = 16;
	localparam int STEP_W     = IW_W + FRAC_W;
	localparam int FX_W       = STEP_W + COL_W;
	localparam int SCOL_W     = FX_W - FRAC_W;
	localparam int SROW_W     = IH_W;
	localparam int MUL_W      = SROW_W + IW_W;
	localparam int RAW_W      = MUL_W + 1;
	localparam int RPROD_W    = ROW_W + IH_W;
	localparam int DIV_N_W    = STEP_W;
	localparam int ACTION_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = IW_W;

	localparam logic [ACTION_W-1:0] ACT_PAL_WR = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TEX_WR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 2'd3;

	typedef struct packed {
		logic                 en;
		logic [PAL_IDX_W-1:0] index;
		logic [COLOR_W-1:0]   data;
	} pal_wr_t;

endpackage

`default_nettype wire

// ----- rtl/ptsp_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, shared by all divisions.
`default_nettype none

module ptsp_div #(
	parameter int N_W = 26,
	parameter int D_W = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [N_W-1:0] dividend,
	input  wire logic [D_W-1:0] divisor,
	output logic                done,
	output logic [N_W-1:0]      quotient,
	output logic [D_W-1:0]      remainder
);

	localparam int CNT_W = $clog2(N_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dsr_q;
	logic [D_W:0]     trial;
	logic [D_W:0]     diff;
	logic             ge;

	assign trial = {rem_q, quo_q[N_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(N_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			quo_q <= {quo_q[N_W-2:0], ge};
			rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ----- rtl/ptsp_store.sv -----
// Source image and palette memories with the two-step color lookup chain.
`default_nettype none

module ptsp_store #(
	parameter int SRC_DEPTH = 131072,
	localparam int SA_W = $clog2(SRC_DEPTH)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ptsp_pkg::pal_wr_t               pal_wr,
	input  wire logic                            src_we,
	input  wire logic [SA_W-1:0]                 src_waddr,
	input  wire logic [ptsp_pkg::TEXEL_W-1:0]    src_wdata,
	input  wire logic                            look_req,
	input  wire logic [SA_W-1:0]                 look_addr,
	output logic                                 look_valid,
	output logic [ptsp_pkg::COLOR_W-1:0]         look_color
);

	import ptsp_pkg::*;

	logic [TEXEL_W-1:0] src_mem [SRC_DEPTH];
	logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];

	logic               valid_s1;
	logic               valid_s2;
	logic [TEXEL_W-1:0] src_rd_s1;
	logic [COLOR_W-1:0] pal_rd_s2;

	always_ff @(posedge clk) begin
		if (src_we) begin
			src_mem[src_waddr] <= src_wdata;
		end
		if (look_req) begin
			src_rd_s1 <= src_mem[look_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pal_wr.en) begin
			pal_mem[pal_wr.index] <= pal_wr.data;
		end
		if (valid_s1) begin
			pal_rd_s2 <= pal_mem[src_rd_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= look_req;
			valid_s2 <= valid_s1;
		end
	end

	assign look_valid = valid_s2;
	assign look_color = pal_rd_s2;

endmodule

`default_nettype wire

// ----- rtl/palette_texel_scale_or_pad.sv -----
// Top level of the palette texel resampler: command sequencer and datapath.
//
// Requests enter on start while busy is low, with action selecting the kind.
// A palette write or a texel write gives no result; with a non-power-of-two
// source depth a texel write holds busy while the shared divider reduces its
// address.
// A pixel read always gives one result: done is high for exactly one cycle
// with pixel_color and out_of_range, and the receiver cannot stall it.
// A read outside the output size is answered from the evaluation state.
// A read in pad mode clamps row and column to the source size. A read in
// scale mode waits on the shared divider for the source row, and once more
// for the column step after in_width or out_width is written; a
// non-power-of-two source depth adds one more divider pass for the address.
// The lookup reads the source memory, then the palette memory.
// Configuration writes on cfg_we take effect at once; the user must make
// them while idle, as the block itself does not enforce it.
// Reset sets all four sizes to one and leaves both memories unwritten.

`default_nettype none

module palette_texel_scale_or_pad #(
	parameter int MAX_IN_WIDTH  = 512,
	parameter int MAX_IN_HEIGHT = 256
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [ptsp_pkg::ACTION_W-1:0]     action,
	input  wire logic [ptsp_pkg::PAL_IDX_W-1:0]    palette_index,
	input  wire logic [ptsp_pkg::COLOR_W-1:0]      palette_color,
	input  wire logic [ptsp_pkg::TADDR_W-1:0]      texel_address,
	input  wire logic [ptsp_pkg::TEXEL_W-1:0]      texel_value,
	input  wire logic [ptsp_pkg::ROW_W-1:0]        out_row,
	input  wire logic [ptsp_pkg::COL_W-1:0]        out_col,
	output logic                                   done,
	output logic [ptsp_pkg::COLOR_W-1:0]           pixel_color,
	output logic                                   out_of_range,
	input  wire logic                              cfg_we,
	input  wire logic [ptsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [ptsp_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import ptsp_pkg::*;

	localparam int SRC_DEPTH = MAX_IN_WIDTH * MAX_IN_HEIGHT;
	localparam int SA_W      = $clog2(SRC_DEPTH);
	localparam bit SRC_POW2  = (SRC_DEPTH & (SRC_DEPTH - 1)) == 0;
	localparam int RX_W      = (RAW_W > SA_W) ? RAW_W : SA_W;
	localparam int DIV_D_W   = (IW_W > SA_W + 1) ? IW_W : SA_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_STEP,
		ST_ROW,
		ST_MUL,
		ST_ADD,
		ST_MOD,
		ST_RMOD,
		ST_LOOK,
		ST_WMOD
	} state_t;

	state_t state_q;

	logic [IW_W-1:0] in_width_q;
	logic [IH_W-1:0] in_height_q;
	logic [IW_W-1:0] out_width_q;
	logic [IH_W-1:0] out_height_q;
	logic            step_dirty_q;

	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [TEXEL_W-1:0] tval_q;
	logic [SROW_W-1:0]  rsel_q;
	logic [SCOL_W-1:0]  csel_q;
	logic [STEP_W-1:0]  step_q;
	logic [FX_W-1:0]    prod_q;
	logic [FX_W-1:0]    fx_q;
	logic [MUL_W-1:0]   mul_q;
	logic [RAW_W-1:0]   raw_q;

	logic               done_q;
	logic [COLOR_W-1:0] pixel_color_q;
	logic               oor_q;

	logic               accept;
	logic               oor;
	logic               pad;
	logic [IH_W-1:0]    last_row;
	logic [IW_W-1:0]    last_col;
	logic [IH_W-1:0]    row_ext;
	logic [IW_W-1:0]    col_ext;
	logic [RPROD_W-1:0] row_prod;
	logic [RX_W-1:0]    taddr_x;
	logic [RX_W-1:0]    raw_x;

	logic               div_start;
	logic [DIV_N_W-1:0] div_dividend;
	logic [DIV_D_W-1:0] div_divisor;
	logic               div_done;
	logic [DIV_N_W-1:0] div_quo;
	logic [DIV_D_W-1:0] div_rem;

	pal_wr_t            pal_wr;
	logic               src_we;
	logic [SA_W-1:0]    src_waddr;
	logic [TEXEL_W-1:0] src_wdata;
	logic               look_req;
	logic [SA_W-1:0]    look_addr;
	logic               look_valid;
	logic [COLOR_W-1:0] look_color;

	assign busy   = state_q != ST_IDLE;
	assign accept = start && !busy;

	assign row_ext  = {1'b0, row_q};
	assign col_ext  = {1'b0, col_q};
	assign oor      = (row_ext >= out_height_q) || (col_ext >= out_width_q);
	assign pad      = (out_width_q >= in_width_q) && (out_height_q >= in_height_q);
	assign last_row = (in_height_q == '0) ? '0 : in_height_q - 1'b1;
	assign last_col = (in_width_q == '0) ? '0 : in_width_q - 1'b1;
	assign row_prod = {{IH_W{1'b0}}, row_q} * {{ROW_W{1'b0}}, in_height_q};
	assign taddr_x  = RX_W'(texel_address);
	assign raw_x    = RX_W'(raw_q);

	// Configuration registers; a new width invalidates the cached column step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_width_q   <= IW_W'(1);
			in_height_q  <= IH_W'(1);
			out_width_q  <= IW_W'(1);
			out_height_q <= IH_W'(1);
			step_dirty_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IN_WIDTH: begin
						in_width_q   <= cfg_data[IW_W-1:0];
						step_dirty_q <= 1'b1;
					end
					CFG_IN_HEIGHT: begin
						in_height_q <= cfg_data[IH_W-1:0];
					end
					CFG_OUT_WIDTH: begin
						out_width_q  <= cfg_data[IW_W-1:0];
						step_dirty_q <= 1'b1;
					end
					CFG_OUT_HEIGHT: begin
						out_height_q <= cfg_data[IH_W-1:0];
					end
				endcase
			end else if (state_q == ST_STEP && div_done) begin
				step_dirty_q <= 1'b0;
			end
		end
	end

	// Requests to the shared divider.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = DIV_N_W'(row_prod);
		div_divisor  = DIV_D_W'(out_height_q);
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_TEX_WR && !SRC_POW2) begin
					div_start    = 1'b1;
					div_dividend = DIV_N_W'(texel_address);
					div_divisor  = DIV_D_W'(SRC_DEPTH);
				end
			end
			ST_EVAL: begin
				if (!oor && !pad) begin
					div_start = 1'b1;
					if (step_dirty_q) begin
						div_dividend = {in_width_q, {FRAC_W{1'b0}}};
						div_divisor  = DIV_D_W'(out_width_q);
					end
				end
			end
			ST_STEP: begin
				div_start = div_done;
			end
			ST_MOD: begin
				if (!SRC_POW2) begin
					div_start    = 1'b1;
					div_dividend = DIV_N_W'(raw_q);
					div_divisor  = DIV_D_W'(SRC_DEPTH);
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// Requests to the memories.
	always_comb begin
		pal_wr.en    = accept && action == ACT_PAL_WR;
		pal_wr.index = palette_index;
		pal_wr.data  = palette_color;
		if (state_q == ST_WMOD) begin
			src_we    = div_done;
			src_waddr = div_rem[SA_W-1:0];
			src_wdata = tval_q;
		end else begin
			src_we    = accept && action == ACT_TEX_WR && SRC_POW2;
			src_waddr = taddr_x[SA_W-1:0];
			src_wdata = texel_value;
		end
		if (SRC_POW2) begin
			look_req  = state_q == ST_MOD;
			look_addr = raw_x[SA_W-1:0];
		end else begin
			look_req  = state_q == ST_RMOD && div_done;
			look_addr = div_rem[SA_W-1:0];
		end
	end

	// Column accumulator, settled before the row quotient, and texel address.
	always_ff @(posedge clk) begin
		prod_q <= {{STEP_W{1'b0}}, col_q} * {{COL_W{1'b0}}, step_q};
		fx_q   <= {{(COL_W + 1){1'b0}}, step_q[STEP_W-1:1]} + prod_q;
		mul_q  <= {{IW_W{1'b0}}, rsel_q} * {{SROW_W{1'b0}}, in_width_q};
		raw_q  <= {1'b0, mul_q} + RAW_W'(csel_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			done_q        <= 1'b0;
			oor_q         <= 1'b0;
			pixel_color_q <= '0;
			row_q         <= '0;
			col_q         <= '0;
			tval_q        <= '0;
			rsel_q        <= '0;
			csel_q        <= '0;
			step_q        <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						row_q  <= out_row;
						col_q  <= out_col;
						tval_q <= texel_value;
						if (action == ACT_READ) begin
							state_q <= ST_EVAL;
						end else if (action == ACT_TEX_WR && !SRC_POW2) begin
							state_q <= ST_WMOD;
						end
					end
				end
				ST_EVAL: begin
					if (oor) begin
						pixel_color_q <= '0;
						oor_q         <= 1'b1;
						done_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end else if (pad) begin
						rsel_q  <= (row_ext > last_row) ? last_row : row_ext;
						csel_q  <= SCOL_W'((col_ext > last_col) ? last_col : col_ext);
						state_q <= ST_MUL;
					end else if (step_dirty_q) begin
						state_q <= ST_STEP;
					end else begin
						state_q <= ST_ROW;
					end
				end
				ST_STEP: begin
					if (div_done) begin
						step_q  <= div_quo[STEP_W-1:0];
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (div_done) begin
						rsel_q  <= div_quo[SROW_W-1:0];
						csel_q  <= fx_q[FX_W-1:FRAC_W];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					state_q <= SRC_POW2 ? ST_LOOK : ST_RMOD;
				end
				ST_RMOD: begin
					if (div_done) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (look_valid) begin
						pixel_color_q <= look_color;
						oor_q         <= 1'b0;
						done_q        <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_WMOD: begin
					if (div_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign pixel_color  = pixel_color_q;
	assign out_of_range = oor_q;

	ptsp_div #(
		.N_W(DIV_N_W),
		.D_W(DIV_D_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	ptsp_store #(
		.SRC_DEPTH(SRC_DEPTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.pal_wr     (pal_wr),
		.src_we     (src_we),
		.src_waddr  (src_waddr),
		.src_wdata  (src_wdata),
		.look_req   (look_req),
		.look_addr  (look_addr),
		.look_valid (look_valid),
		.look_color (look_color)
	);

endmodule

`default_nettype wire

// ----- rtl/ptsp_check.sv -----
// Port-level checks for the palette texel resampler and their bind.
`default_nettype none

module ptsp_check (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              start,
	input wire logic                              busy,
	input wire logic [ptsp_pkg::ACTION_W-1:0]     action,
	input wire logic                              done,
	input wire logic [ptsp_pkg::COLOR_W-1:0]      pixel_color,
	input wire logic                              out_of_range
);

	import ptsp_pkg::*;

	// An accepted read always raises busy in the cycle after it is taken.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_READ |=> busy)
		else $error("read request did not raise busy");

	// Results appear only as the block finishes a read and goes idle.
	a_done_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without a finishing read");

	// A request other than a read, taken while idle, is not directly followed by a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action != ACT_READ |=> !done)
		else $error("write request produced a result");

	// A result is never repeated back to back.
	a_single_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result repeated");

	// An out-of-range result carries a zero color.
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> pixel_color == '0)
		else $error("out-of-range result with nonzero color");

endmodule

bind palette_texel_scale_or_pad ptsp_check u_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.action       (action),
	.done         (done),
	.pixel_color  (pixel_color),
	.out_of_range (out_of_range)
);

`default_nettype wire

// ----- tb/sv/palette_texel_scale_or_pad_test.sv -----
// Self-checking testbench for the palette texel resampler with a built-in pixel predictor.
module palette_texel_scale_or_pad_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ptsp_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1900;
	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic [ACTION_W-1:0]  act;
		logic [PAL_IDX_W-1:0] pal_idx;
		logic [COLOR_W-1:0]   pal_color;
		logic [TADDR_W-1:0]   taddr;
		logic [TEXEL_W-1:0]   tval;
		logic [ROW_W-1:0]     row;
		logic [COL_W-1:0]     col;
	} request_t;

	typedef struct {
		logic [COLOR_W-1:0] color;
		logic               oor;
	} pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [ACTION_W-1:0]   action = '0;
	logic [PAL_IDX_W-1:0]  palette_index = '0;
	logic [COLOR_W-1:0]    palette_color = '0;
	logic [TADDR_W-1:0]    texel_address = '0;
	logic [TEXEL_W-1:0]    texel_value = '0;
	logic [ROW_W-1:0]      out_row = '0;
	logic [COL_W-1:0]      out_col = '0;
	logic                  done;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  out_of_range;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [COLOR_W-1:0] palette_copy [PAL_DEPTH];
	bit                 palette_set [PAL_DEPTH];
	logic [TEXEL_W-1:0] texel_copy [1 << TADDR_W];
	bit                 texel_set [1 << TADDR_W];
	int unsigned        src_w = 1, src_h = 1, dst_w = 1, dst_h = 1;

	pixel_t pending_pixels[$];
	int     errors = 0;
	int     items_sent = 0;
	int     stall_cycles = 0;
	bit     idle_bursts = 1'b1;

	palette_texel_scale_or_pad dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.palette_index(palette_index),
		.palette_color(palette_color),
		.texel_address(texel_address),
		.texel_value(texel_value),
		.out_row(out_row),
		.out_col(out_col),
		.done(done),
		.pixel_color(pixel_color),
		.out_of_range(out_of_range),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic bit pixel_in_range(int unsigned row, int unsigned col);
		return row < dst_h && col < dst_w;
	endfunction

	// Source address of an in-range output pixel, wrapped to the store depth.
	function automatic logic [TADDR_W-1:0] texel_addr_of(int unsigned row, int unsigned col);
		logic [63:0] r, c, step, acc, a;
		if (dst_w >= src_w && dst_h >= src_h) begin
			r = row;
			c = col;
			if (src_h == 0) r = 0;
			else if (r > src_h - 1) r = src_h - 1;
			if (src_w == 0) c = 0;
			else if (c > src_w - 1) c = src_w - 1;
		end else begin
			step = src_w;
			step = (step << FRAC_W) / dst_w;
			acc = (step >> 1) + col * step;
			c = acc >> FRAC_W;
			r = row;
			r = (r * src_h) / dst_h;
		end
		a = r * src_w + c;
		return a[TADDR_W-1:0];
	endfunction

	task automatic resample_predict(request_t r);
		pixel_t px;
		logic [TADDR_W-1:0] a;
		case (r.act)
			ACT_PAL_WR: begin
				palette_copy[r.pal_idx] = r.pal_color;
				palette_set[r.pal_idx] = 1'b1;
			end
			ACT_TEX_WR: begin
				texel_copy[r.taddr] = r.tval;
				texel_set[r.taddr] = 1'b1;
			end
			ACT_READ: begin
				if (!pixel_in_range(r.row, r.col)) begin
					px.color = '0;
					px.oor = 1'b1;
				end else begin
					a = texel_addr_of(r.row, r.col);
					px.color = palette_copy[texel_copy[a]];
					px.oor = 1'b0;
				end
				pending_pixels.push_back(px);
			end
			default: ;
		endcase
	endtask

	function automatic request_t make_request(logic [ACTION_W-1:0] act);
		request_t r;
		r.act = act;
		r.pal_idx = $urandom;
		r.pal_color = $urandom;
		r.taddr = $urandom;
		r.tval = $urandom;
		r.row = $urandom;
		r.col = $urandom;
		return r;
	endfunction

	task automatic send_request(request_t r);
		start <= 1'b1;
		action <= r.act;
		palette_index <= r.pal_idx;
		palette_color <= r.pal_color;
		texel_address <= r.taddr;
		texel_value <= r.tval;
		out_row <= r.row;
		out_col <= r.col;
		@(posedge clk);
		while (busy) @(posedge clk);
		resample_predict(r);
		if (r.act != ACT_UNUSED) items_sent++;
		if (idle_bursts && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic write_palette(logic [PAL_IDX_W-1:0] idx, logic [COLOR_W-1:0] color);
		request_t r;
		r = make_request(ACT_PAL_WR);
		r.pal_idx = idx;
		r.pal_color = color;
		send_request(r);
	endtask

	task automatic write_texel(logic [TADDR_W-1:0] addr, logic [TEXEL_W-1:0] value);
		request_t r;
		r = make_request(ACT_TEX_WR);
		r.taddr = addr;
		r.tval = value;
		send_request(r);
	endtask

	// Loads the texel and palette entry behind the pixel first if they were never written.
	task automatic read_pixel(int unsigned row, int unsigned col);
		request_t r;
		logic [TADDR_W-1:0] a;
		if (pixel_in_range(row, col)) begin
			a = texel_addr_of(row, col);
			if (!texel_set[a]) write_texel(a, $urandom);
			if (!palette_set[texel_copy[a]]) write_palette(texel_copy[a], $urandom);
		end
		r = make_request(ACT_READ);
		r.row = row;
		r.col = col;
		send_request(r);
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		case (idx)
			CFG_IN_WIDTH:   src_w = value & ((1 << IW_W) - 1);
			CFG_IN_HEIGHT:  src_h = value & ((1 << IH_W) - 1);
			CFG_OUT_WIDTH:  dst_w = value & ((1 << IW_W) - 1);
			CFG_OUT_HEIGHT: dst_h = value & ((1 << IH_W) - 1);
			default: ;
		endcase
	endtask

	task automatic set_sizes(int unsigned iw, int unsigned ih, int unsigned ow, int unsigned oh);
		wait_idle();
		write_reg(CFG_IN_WIDTH, iw);
		write_reg(CFG_IN_HEIGHT, ih);
		write_reg(CFG_OUT_WIDTH, ow);
		write_reg(CFG_OUT_HEIGHT, oh);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_sizes();
		write_palette(8'hFF, 32'hFFFF_FFFF);
		write_palette(8'h00, 32'h0000_0000);
		write_texel(17'h1FFFF, 8'hFF);
		write_texel(17'h00000, 8'h00);
		read_pixel(0, 0);
		read_pixel(0, 1);
		read_pixel(1, 0);
		read_pixel(255, 511);
	endtask

	task automatic test_pad_clamp();
		set_sizes(5, 3, 16, 8);
		read_pixel(0, 0);
		read_pixel(2, 4);
		read_pixel(7, 15);
		read_pixel(7, 0);
		read_pixel(0, 15);
		read_pixel(8, 0);
		read_pixel(0, 16);
	endtask

	task automatic test_size_extremes();
		set_sizes(512, 256, 4, 1);
		for (int c = 0; c < 4; c++) read_pixel(0, c);
		set_sizes(512, 256, 512, 255);
		read_pixel(254, 511);
		read_pixel(0, 0);
		set_sizes(512, 256, 512, 256);
		read_pixel(255, 511);
		set_sizes(1, 1, 512, 256);
		read_pixel(255, 511);
		read_pixel(0, 0);
	endtask

	task automatic test_zero_sizes();
		set_sizes(4, 4, 0, 8);
		read_pixel(0, 0);
		set_sizes(4, 4, 8, 0);
		read_pixel(0, 0);
		set_sizes(0, 4, 8, 8);
		read_pixel(3, 7);
		read_pixel(7, 0);
		set_sizes(4, 0, 8, 8);
		read_pixel(7, 7);
		set_sizes(0, 8, 4, 4);
		read_pixel(3, 3);
	endtask

	task automatic test_odd_width();
		set_sizes(100, 50, 37, 25);
		read_pixel(24, 36);
		read_pixel(3, 36);
		read_pixel(4, 0);
		read_pixel(3, 37);
	endtask

	task automatic test_address_wrap();
		set_sizes(1023, 200, 1023, 255);
		read_pixel(199, 511);
		read_pixel(254, 300);
		set_sizes(1023, 256, 512, 200);
		read_pixel(199, 511);
		read_pixel(130, 10);
	endtask

	task automatic test_unused_action();
		repeat (3) send_request(make_request(ACT_UNUSED));
		read_pixel(0, 0);
	endtask

	task automatic run_phase(int unsigned count);
		int unsigned pick, row_max, col_max;
		bit has_pixels;
		has_pixels = dst_w > 0 && dst_h > 0;
		row_max = (dst_h > 256 ? 256 : dst_h) - 1;
		col_max = (dst_w > 512 ? 512 : dst_w) - 1;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 55 && has_pixels)
				read_pixel($urandom_range(0, row_max), $urandom_range(0, col_max));
			else if (pick < 65)
				read_pixel($urandom_range(0, 255), $urandom_range(0, 511));
			else if (pick < 77 && has_pixels)
				write_texel(texel_addr_of($urandom_range(0, row_max),
					$urandom_range(0, col_max)), $urandom);
			else if (pick < 85)
				write_texel($urandom, $urandom);
			else if (pick < 95)
				write_palette($urandom, $urandom);
			else
				send_request(make_request(ACT_UNUSED));
		end
	endtask

	task automatic test_random_phases();
		int unsigned iw, ih, ow, oh;
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: begin
					iw = $urandom_range(1, 16);
					ih = $urandom_range(1, 16);
					ow = $urandom_range(iw, 64);
					oh = $urandom_range(ih, 64);
				end
				1: begin
					iw = $urandom_range(1, 512);
					ih = $urandom_range(1, 256);
					ow = $urandom_range(iw, 512);
					oh = $urandom_range(ih, 256);
				end
				2: begin
					iw = $urandom_range(1, 512);
					ih = $urandom_range(1, 256);
					ow = 4 * $urandom_range(1, 128);
					oh = $urandom_range(1, 256);
				end
				default: begin
					iw = $urandom_range(1, 512);
					ih = $urandom_range(1, 256);
					ow = $urandom_range(1, 512);
					oh = $urandom_range(1, 256);
				end
			endcase
			set_sizes(iw, ih, ow, oh);
			idle_bursts = (items_sent + 300 < ITEM_TARGET) && ($urandom_range(0, 3) != 0);
			run_phase(150);
		end
	endtask

	always @(posedge clk) begin : check_results
		pixel_t want;
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual color %h out_of_range %b",
					$time, pixel_color, out_of_range);
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_color !== want.color) begin
					errors++;
					$display("%0t: pixel_color mismatch: expected %h, actual %h",
						$time, want.color, pixel_color);
				end
				if (out_of_range !== want.oor) begin
					errors++;
					$display("%0t: out_of_range mismatch: expected %b, actual %b",
						$time, want.oor, out_of_range);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((start && !busy) || done || cfg_we)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_sizes();
		test_pad_clamp();
		test_size_extremes();
		test_zero_sizes();
		test_odd_width();
		test_address_wrap();
		test_unused_action();
		test_random_phases();
		start <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ptsp_pkg.sv
rtl/ptsp_div.sv
rtl/ptsp_store.sv
rtl/palette_texel_scale_or_pad.sv
rtl/ptsp_check.sv
tb/sv/palette_texel_scale_or_pad_test.sv
